>>> rtl/seahash_streaming_hash_top_macros.svh
// assertion macros shared by the seahash checker
// no dependencies; included by shh_checker.sv
`ifndef SEAHASH_STREAMING_HASH_TOP_MACROS_SVH
`define SEAHASH_STREAMING_HASH_TOP_MACROS_SVH

// implication in the same cycle
`define SHH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("seahash check failed");

// implication in the following cycle
`define SHH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("seahash check failed");

`endif

>>> rtl/shh_pkg.sv
// shared types, constants and the microcode table of the seahash block
// no dependencies; imported by every rtl module of the block
package shh_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned HalfW   = 32;
  localparam int unsigned CountW  = 4;
  localparam int unsigned NumLane = 4;
  localparam int unsigned LaneIdxW = 2;
  localparam int unsigned AddrW   = 5;

  localparam logic [WordW-1:0] MixMult = 64'h07ed0e9fa0d94a33;

  localparam logic [NumLane-1:0][WordW-1:0] SeedReset = {
    64'h14f994a4c5259381, 64'h6fe2e5aaf078ebc9,
    64'hb480a793d8e6c86c, 64'h16f11fe89b0d677c
  };

  typedef logic [2:0] seg_t;
  typedef logic [2:0] step_t;

  // program segments: absorb one word, then four cross mixes and the digest
  localparam seg_t SegAbsorb = 3'd0;
  localparam seg_t SegMix0   = 3'd1;
  localparam seg_t SegMix2   = 3'd2;
  localparam seg_t SegMix1   = 3'd3;
  localparam seg_t SegMix3   = 3'd4;
  localparam seg_t SegDigest = 3'd5;
  localparam step_t LastStep = 3'd5;

  typedef enum logic [2:0] {
    SRC_X, SRC_WORD, SRC_L0, SRC_L1, SRC_L2, SRC_L3, SRC_FIN
  } src_e;

  typedef enum logic [1:0] {
    MO_LL, MO_HL, MO_LH
  } mop_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_LANE, WR_X0, WR_X1, WR_X2, WR_X3, WR_OUT
  } wr_e;

  typedef enum logic [1:0] {
    BR_NEXT, BR_LAST, BR_DONE
  } br_e;

  typedef struct packed {
    src_e src;
    mop_e mop;
    wr_e  wr;
    br_e  br;
  } cw_t;

  typedef struct packed {
    logic run;
    src_e src;
    mop_e mop;
    wr_e  wr;
  } ctrl_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

  function automatic cw_t ucode(seg_t seg, step_t step);
    cw_t  cw;
    src_e seg_src;
    wr_e  seg_wr;
    br_e  seg_br;
    unique case (seg)
      SegAbsorb: begin seg_src = SRC_WORD; seg_wr = WR_LANE; seg_br = BR_LAST; end
      SegMix0:   begin seg_src = SRC_L1;   seg_wr = WR_X0;   seg_br = BR_NEXT; end
      SegMix2:   begin seg_src = SRC_L3;   seg_wr = WR_X2;   seg_br = BR_NEXT; end
      SegMix1:   begin seg_src = SRC_L0;   seg_wr = WR_X1;   seg_br = BR_NEXT; end
      SegMix3:   begin seg_src = SRC_L2;   seg_wr = WR_X3;   seg_br = BR_NEXT; end
      SegDigest: begin seg_src = SRC_FIN;  seg_wr = WR_OUT;  seg_br = BR_DONE; end
      default:   begin seg_src = SRC_X;    seg_wr = WR_NONE; seg_br = BR_DONE; end
    endcase
    cw.src = SRC_X;
    cw.wr  = WR_NONE;
    cw.br  = seg_br;
    // each diffusion: xorshift+low mult, two cross terms, twice over
    unique case (step)
      3'd0:    begin cw.mop = MO_LL; cw.src = seg_src; end
      3'd1:    cw.mop = MO_HL;
      3'd2:    cw.mop = MO_LH;
      3'd3:    cw.mop = MO_LL;
      3'd4:    cw.mop = MO_HL;
      3'd5:    begin cw.mop = MO_LH; cw.wr = seg_wr; end
      default: cw.mop = MO_LL;
    endcase
    return cw;
  endfunction

endpackage

>>> rtl/shh_cfg_regs.sv
// apb-style seed registers of the seahash block
// depends on shh_pkg
module shh_cfg_regs (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             psel,
  input  logic                                             penable,
  input  logic                                             pwrite,
  input  logic [shh_pkg::AddrW-1:0]                        paddr,
  input  logic [shh_pkg::WordW-1:0]                        pwdata,
  output logic [shh_pkg::WordW-1:0]                        prdata,
  output logic                                             pready,
  output logic [shh_pkg::NumLane-1:0][shh_pkg::WordW-1:0]  seeds_o
);
  import shh_pkg::*;

  logic [NumLane-1:0][WordW-1:0] seed_q, seed_d;
  logic [LaneIdxW-1:0]           reg_idx;

  // registers sit on 8-byte boundaries
  assign reg_idx = paddr[AddrW-1:3];
  assign pready  = 1'b1;
  assign prdata  = seed_q[reg_idx];
  assign seeds_o = seed_q;

  always_comb begin
    seed_d = seed_q;
    if (psel && penable && pwrite) begin
      seed_d[reg_idx] = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else begin
      seed_q <= seed_d;
    end
  end

endmodule

>>> rtl/shh_seq.sv
// microcode sequencer: segment and step counters, program table lookup, branches
// depends on shh_pkg
module shh_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [shh_pkg::CountW-1:0]  byte_count_i,
  input  logic                        last_i,
  input  shh_pkg::stat_t              stat_i,
  output shh_pkg::ctrl_t              ctrl_o
);
  import shh_pkg::*;

  logic  busy_q, busy_d;
  logic  last_q, last_d;
  seg_t  seg_q, seg_d;
  step_t step_q, step_d;
  cw_t   cw;
  logic  stall, run, accept;

  assign cw     = ucode(seg_q, step_q);
  assign stall  = (cw.wr == WR_OUT) && stat_i.out_full;
  assign run    = busy_q && !stall;
  assign accept = in_valid_i && !busy_q;

  assign in_ready_o = !busy_q;
  assign ctrl_o     = '{run: run, src: cw.src, mop: cw.mop, wr: cw.wr};

  always_comb begin
    busy_d = busy_q;
    last_d = last_q;
    seg_d  = seg_q;
    step_d = step_q;
    if (accept) begin
      last_d = last_i;
      step_d = '0;
      // an empty request goes straight to the finish, or does nothing
      if (byte_count_i != '0) begin
        busy_d = 1'b1;
        seg_d  = SegAbsorb;
      end else if (last_i) begin
        busy_d = 1'b1;
        seg_d  = SegMix0;
      end
    end else if (run) begin
      if (step_q == LastStep) begin
        step_d = '0;
        unique case (cw.br)
          BR_NEXT: seg_d = seg_q + 3'd1;
          BR_LAST: begin
            if (last_q) begin
              seg_d = SegMix0;
            end else begin
              busy_d = 1'b0;
            end
          end
          BR_DONE: busy_d = 1'b0;
          default: busy_d = 1'b0;
        endcase
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      last_q <= 1'b0;
      seg_q  <= SegAbsorb;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      last_q <= last_d;
      seg_q  <= seg_d;
      step_q <= step_d;
    end
  end

endmodule

>>> rtl/shh_datapath.sv
// lanes, word capture, shared 32x32 multiplier and digest register
// depends on shh_pkg; driven by shh_seq
module shh_datapath (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             accept_i,
  input  logic [shh_pkg::WordW-1:0]                        data_bytes_i,
  input  logic [shh_pkg::CountW-1:0]                       byte_count_i,
  input  logic [shh_pkg::NumLane-1:0][shh_pkg::WordW-1:0]  seeds_i,
  input  shh_pkg::ctrl_t                                   ctrl_i,
  output shh_pkg::stat_t                                   stat_o,
  output logic                                             out_valid_o,
  input  logic                                             out_ready_i,
  output logic [shh_pkg::WordW-1:0]                        digest_o
);
  import shh_pkg::*;

  logic [NumLane-1:0][WordW-1:0] lanes_q, lanes_d;
  logic [LaneIdxW-1:0]           ptr_q, ptr_d;
  logic [WordW-1:0]              cnt_q, cnt_d;
  logic [WordW-1:0]              word_q, word_d;
  logic [WordW-1:0]              x_q, x_d;
  logic [WordW-1:0]              acc_q, acc_d;
  logic [WordW-1:0]              digest_q, digest_d;
  logic                          out_valid_q, out_valid_d;

  logic [WordW-1:0]  tail_w, src_v, mul_in, sum;
  logic [HalfW-1:0]  op_a, op_b;
  logic [WordW-1:0]  prod;
  logic [2:0]        tail_n;

  // tail bytes pack first byte most significant
  assign tail_n = byte_count_i[2:0];
  always_comb begin
    tail_w = '0;
    for (int k = 0; k < 8; k++) begin
      for (int j = 0; j < 8; j++) begin
        if ((k < int'(tail_n)) && (j + k + 1 == int'(tail_n))) begin
          tail_w[8*j +: 8] = data_bytes_i[8*k +: 8];
        end
      end
    end
  end
  assign word_d = accept_i ? (byte_count_i[3] ? data_bytes_i : tail_w) : word_q;

  always_comb begin
    unique case (ctrl_i.src)
      SRC_X:    src_v = x_q;
      SRC_WORD: src_v = lanes_q[ptr_q] ^ word_q;
      SRC_L0:   src_v = lanes_q[0];
      SRC_L1:   src_v = lanes_q[1];
      SRC_L2:   src_v = lanes_q[2];
      SRC_L3:   src_v = lanes_q[3];
      SRC_FIN:  src_v = lanes_q[1] ^ lanes_q[3] ^ cnt_q;
      default:  src_v = x_q;
    endcase
  end

  // fresh operands get the leading xorshift of the diffusion
  assign mul_in = (ctrl_i.src == SRC_X) ? src_v : (src_v ^ (src_v >> HalfW));

  always_comb begin
    unique case (ctrl_i.mop)
      MO_LL:   begin op_a = mul_in[HalfW-1:0];     op_b = MixMult[HalfW-1:0];     end
      MO_HL:   begin op_a = x_q[WordW-1:HalfW];    op_b = MixMult[HalfW-1:0];     end
      MO_LH:   begin op_a = x_q[HalfW-1:0];        op_b = MixMult[WordW-1:HalfW]; end
      default: begin op_a = x_q[HalfW-1:0];        op_b = MixMult[HalfW-1:0];     end
    endcase
  end

  assign prod = WordW'(op_a) * WordW'(op_b);
  assign sum  = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};

  always_comb begin
    x_d   = x_q;
    acc_d = acc_q;
    if (ctrl_i.run) begin
      unique case (ctrl_i.mop)
        MO_LL:   begin x_d = mul_in; acc_d = prod; end
        MO_HL:   acc_d = sum;
        MO_LH:   x_d = sum ^ (sum >> HalfW);
        default: acc_d = acc_q;
      endcase
    end
  end

  always_comb begin
    lanes_d     = lanes_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    digest_d    = digest_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (ctrl_i.run) begin
      unique case (ctrl_i.wr)
        WR_NONE: ;
        WR_LANE: begin
          lanes_d[ptr_q] = x_d;
          ptr_d          = ptr_q + 2'd1;
          cnt_d          = cnt_q + 64'd1;
        end
        WR_X0: lanes_d[0] = lanes_q[0] ^ x_d;
        WR_X1: lanes_d[1] = lanes_q[1] ^ x_d;
        WR_X2: lanes_d[2] = lanes_q[2] ^ x_d;
        WR_X3: lanes_d[3] = lanes_q[3] ^ x_d;
        WR_OUT: begin
          digest_d    = x_d;
          out_valid_d = 1'b1;
          lanes_d     = seeds_i;
          ptr_d       = '0;
          cnt_d       = '0;
        end
        default: ;
      endcase
    end
  end

  assign stat_o      = '{out_full: out_valid_q && !out_ready_i};
  assign out_valid_o = out_valid_q;
  assign digest_o    = digest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q     <= SeedReset;
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      lanes_q     <= lanes_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    x_q      <= x_d;
    acc_q    <= acc_d;
    digest_q <= digest_d;
  end

endmodule

>>> rtl/seahash_streaming_hash_top.sv
// seahash streaming hash: one 32x32 multiplier, three products per 64-bit multiply and two
// multiplies per diffusion; a new request is taken only once the one before it is done
// a last request adds five finishing diffusions (an empty one skips the absorb) before the
// digest is valid; the digest write waits while an earlier digest is still unread, and an
// empty non-last request leaves the block ready; reset clears control, loads default seeds,
// no clearing
module seahash_streaming_hash_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [shh_pkg::WordW-1:0]   data_bytes_i,
  input  logic [shh_pkg::CountW-1:0]  byte_count_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [shh_pkg::WordW-1:0]   digest_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [shh_pkg::AddrW-1:0]   paddr,
  input  logic [shh_pkg::WordW-1:0]   pwdata,
  output logic [shh_pkg::WordW-1:0]   prdata,
  output logic                        pready
);
  import shh_pkg::*;

  logic [NumLane-1:0][WordW-1:0] seeds;
  ctrl_t                         ctrl;
  stat_t                         stat;

  shh_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seeds_o (seeds)
  );

  shh_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .stat_i       (stat),
    .ctrl_o       (ctrl)
  );

  shh_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_valid_i && in_ready_o),
    .data_bytes_i (data_bytes_i),
    .byte_count_i (byte_count_i),
    .seeds_i      (seeds),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digest_o     (digest_o)
  );

endmodule

>>> rtl/shh_checker.sv
// port-level checks of the seahash block, bound to the top level
// depends on shh_pkg and seahash_streaming_hash_top_macros.svh
`include "seahash_streaming_hash_top_macros.svh"

module shh_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [shh_pkg::CountW-1:0]  byte_count_i,
  input logic                        last_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [shh_pkg::WordW-1:0]   digest_o
);
  import shh_pkg::*;

  // a waiting digest holds
  `SHH_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(digest_o))
  // an empty non-final request leaves the block free
  `SHH_ASSERT_NXT(a_empty_free, clk_i, rst_ni, in_valid_i && in_ready_o && byte_count_i == '0 && !last_i, in_ready_o)
  // a request with work keeps the block busy
  `SHH_ASSERT_NXT(a_work_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (byte_count_i != '0 || last_i), !in_ready_o)
  // a digest only appears at the end of a busy spell
  `SHH_ASSERT_IMP(a_out_after_busy, clk_i, rst_ni, $rose(out_valid_o), $past(!in_ready_o))

endmodule

bind seahash_streaming_hash_top shh_checker u_checker (.*);

>>> tb/seahash_streaming_hash_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the seahash streaming hash block: a built-in predictor
// tracks lanes, pointer, word count and seeds; depends on shh_pkg and seahash_streaming_hash_top
module seahash_streaming_hash_top_test;
  import shh_pkg::*;

  localparam int unsigned Limit        = 400000;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned RegStride    = 8;
  localparam logic [63:0] DiffuseMult  = 64'h07ed0e9fa0d94a33;
  localparam logic [63:0] AllOnes      = '1;

  typedef enum int unsigned {
    SEED_LANE0, SEED_LANE1, SEED_LANE2, SEED_LANE3
  } seed_reg_e;

  typedef struct packed {
    logic [WordW-1:0]  data;
    logic [CountW-1:0] count;
    logic              last;
  } hash_req_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [WordW-1:0]  data_bytes_i = '0;
  logic [CountW-1:0] byte_count_i = '0;
  logic              last_i       = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [WordW-1:0]  digest_o;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [AddrW-1:0]  paddr        = '0;
  logic [WordW-1:0]  pwdata       = '0;
  logic [WordW-1:0]  prdata;
  logic              pready;

  // predictor state
  logic [63:0] seed_copy [4];
  logic [63:0] lane_copy [4];
  logic [1:0]  lane_ptr;
  logic [63:0] words_absorbed;

  hash_req_t   pending_reqs[$];
  logic [63:0] expected_digests[$];

  int unsigned mismatch_cnt   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go        = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned cycle_cnt      = 0;

  seahash_streaming_hash_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_bytes_i (data_bytes_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digest_o     (digest_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [63:0] seahash_diffuse(input logic [63:0] x);
    logic [63:0] v;
    v = x ^ (x >> 32);
    v = v * DiffuseMult;
    v = v ^ (v >> 32);
    v = v * DiffuseMult;
    return v ^ (v >> 32);
  endfunction

  function automatic void reload_lanes();
    for (int k = 0; k < 4; k++) lane_copy[k] = seed_copy[k];
    lane_ptr       = '0;
    words_absorbed = '0;
  endfunction

  function automatic void absorb_request(input hash_req_t r);
    int unsigned n;
    logic [63:0] w;
    logic [63:0] v0, v1, v2, v3;
    n = (r.count > 8) ? 8 : r.count;
    if (n != 0) begin
      if (n == 8) begin
        w = r.data;
      end else begin
        // tail word: first byte ends up most significant
        w = '0;
        for (int k = 0; k < n; k++) w = (w << 8) | 64'(r.data[8*k +: 8]);
      end
      lane_copy[lane_ptr] = seahash_diffuse(lane_copy[lane_ptr] ^ w);
      lane_ptr++;
      words_absorbed++;
    end
    if (r.last) begin
      v0 = lane_copy[0] ^ seahash_diffuse(lane_copy[1]);
      v2 = lane_copy[2] ^ seahash_diffuse(lane_copy[3]);
      v1 = lane_copy[1] ^ seahash_diffuse(v0);
      v3 = lane_copy[3] ^ seahash_diffuse(v2);
      expected_digests.push_back(seahash_diffuse(v1 ^ v3 ^ words_absorbed));
      reload_lanes();
    end
  endfunction

  // request driver
  always @(posedge clk_i) begin
    hash_req_t cur;
    hash_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        cur.data  = data_bytes_i;
        cur.count = byte_count_i;
        cur.last  = last_i;
        absorb_request(cur);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_valid_i   <= 1'b1;
          data_bytes_i <= nxt.data;
          byte_count_i <= nxt.count;
          last_i       <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // digest monitor
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_digests.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected digest, expected none, got %h", $time, digest_o);
        end else begin
          want = expected_digests.pop_front();
          if (digest_o !== want) begin
            mismatch_cnt++;
            $display("%0t: digest mismatch, expected %h, got %h", $time, want, digest_o);
          end
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_go) hold_left <= HoldCycles;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic write_seed(input seed_reg_e idx, input logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * RegStride);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seed_copy[idx] = value;
  endtask

  task automatic write_seeds(input logic [63:0] s0, input logic [63:0] s1,
                             input logic [63:0] s2, input logic [63:0] s3);
    write_seed(SEED_LANE0, s0);
    write_seed(SEED_LANE1, s1);
    write_seed(SEED_LANE2, s2);
    write_seed(SEED_LANE3, s3);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_digests.size() != 0);
  endtask

  task automatic start_phase(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CountW-1:0] rand_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return CountW'(8);
    if (r < 80) return CountW'($urandom_range(7, 1));
    if (r < 90) return '0;
    return CountW'($urandom_range(15, 9));
  endfunction

  function automatic void push_req(input logic [63:0] data, input logic [CountW-1:0] count,
                                   input logic last);
    hash_req_t r;
    r.data  = data;
    r.count = count;
    r.last  = last;
    pending_reqs.push_back(r);
  endfunction

  // whole messages with random content, last on the final request
  function automatic void queue_messages(input int unsigned n_reqs);
    int unsigned done_reqs;
    int unsigned len;
    done_reqs = 0;
    while (done_reqs < n_reqs) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) push_req(rand_word(), rand_count(), i == len - 1);
      done_reqs += len;
    end
  endfunction

  initial begin
    seed_copy[0] = 64'h16f11fe89b0d677c;
    seed_copy[1] = 64'hb480a793d8e6c86c;
    seed_copy[2] = 64'h6fe2e5aaf078ebc9;
    seed_copy[3] = 64'h14f994a4c5259381;
    reload_lanes();
    wait (rst_ni);
    start_phase(0, 0);

    // directed: empty message, extremes, every tail length, counts above eight
    push_req('0, '0, 1'b1);
    push_req('0, CountW'(8), 1'b0);
    push_req(AllOnes, CountW'(8), 1'b1);
    for (int n = 1; n <= 7; n++) push_req(64'hf0e1d2c3b4a59687, CountW'(n), n == 7);
    push_req(rand_word(), CountW'(9), 1'b0);
    push_req(rand_word(), '0, 1'b0);
    push_req(rand_word(), CountW'(15), 1'b0);
    push_req(64'h8000_0000_0000_0001, CountW'(12), 1'b0);
    push_req(AllOnes, CountW'(5), 1'b1);
    push_req(rand_word(), CountW'(8), 1'b1);
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);

    write_seeds('0, '0, '0, '0);
    start_phase(0, 0);
    queue_messages(85);
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);

    write_seeds(AllOnes, AllOnes, AllOnes, AllOnes);
    start_phase(66, 0);
    queue_messages(85);
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);

    // receiver holds off while the sender keeps offering, so the block backs up
    write_seeds(rand_word(), rand_word(), rand_word(), rand_word());
    start_phase(0, 66);
    queue_messages(85);
    hold_go = 1'b1;
    @(negedge clk_i);
    hold_go = 1'b0;
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);

    // sender pauses half way until every digest is back
    write_seeds('0, AllOnes, rand_word(), 64'h16f11fe89b0d677c);
    start_phase(22, 22);
    queue_messages(45);
    wait_drained();
    queue_messages(45);
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);

    write_seeds(rand_word(), rand_word(), rand_word(), rand_word());
    start_phase(0, 0);
    queue_messages(85);
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);

    if (mismatch_cnt == 0 && expected_digests.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    while (cycle_cnt < Limit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
